/* src/plob_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the price-level order book.
// No dependencies; every other file of the block uses it.
package plob_pkg;

  localparam int LEVELS  = 64;
  localparam int PRICE_W = 32;
  localparam int QTY_W   = 48;
  localparam int REQ_W   = 2;

  localparam logic [REQ_W-1:0] REQ_UPDATE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SNAPSHOT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd2;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } level_t;

  // Compare request, broadcast to every cell on the accepting edge.
  typedef struct packed {
    logic               capture;
    logic               clr;
    logic [PRICE_W-1:0] price;
  } probe_t;

  // Held request, broadcast to every cell while it is applied.
  typedef struct packed {
    logic               apply;
    logic               clr;
    logic               side;
    logic               q_zero;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } cmd_t;

endpackage

/* src/plob_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the order book: level input and top-of-book result.
// Depends on plob_pkg for field widths.
interface plob_in_if;
  logic                          valid;
  logic                          ready;
  logic [plob_pkg::REQ_W-1:0]    req_type;
  logic                          side;
  logic [plob_pkg::PRICE_W-1:0]  level_price;
  logic [plob_pkg::QTY_W-1:0]    level_qty;

  modport source (output valid, req_type, side, level_price, level_qty, input ready);
  modport sink   (input valid, req_type, side, level_price, level_qty, output ready);
endinterface

interface plob_out_if;
  logic                          valid;
  logic                          ready;
  logic [plob_pkg::PRICE_W-1:0]  best_bid_price;
  logic [plob_pkg::QTY_W-1:0]    best_bid_qty;
  logic [plob_pkg::PRICE_W-1:0]  best_ask_price;
  logic [plob_pkg::QTY_W-1:0]    best_ask_qty;
  logic                          bid_present;
  logic                          ask_present;
  logic                          level_dropped;

  modport source (output valid, best_bid_price, best_bid_qty, best_ask_price, best_ask_qty,
                  bid_present, ask_present, level_dropped, input ready);
  modport sink   (input valid, best_bid_price, best_bid_qty, best_ask_price, best_ask_qty,
                  bid_present, ask_present, level_dropped, output ready);
endinterface

/* src/price_level_order_book_top.sv */
`timescale 1ns / 1ps
// Price-level order book with top-of-book reporting.
// Depends on plob_pkg, plob_if and plob_side.
//
// Usage:
//   in_ch carries one level per transfer: req_type (update, snapshot-and-update,
//   clear), side, level_price and level_qty. A zero quantity removes the level.
//   out_ch returns exactly one result per input transfer: best bid and ask price
//   and quantity (zero when the side is empty), present flags, and level_dropped
//   when a full side lost a level: its worst one, or the new one if that ranks worse.
//   Each side is a chain of 64 cells kept sorted, best level in the first cell.
//   An item is handled in order: on the input transfer every cell compares the price
//   against its own level; in the apply step that follows, once the result register
//   is free, the match reduction across the chain steers each cell to hold, update,
//   take its neighbor or take the new level, and the result register loads. No new
//   item is taken in until the apply step of the last one is done.
//   A result waits in the output register while the next item is taken in.
//   If the receiver stalls with a result still held, the apply step waits and
//   in_ch.ready stays low until the result register frees.
//   After reset both sides are empty and no result is pending.
module price_level_order_book_top (
  input  logic       clk,
  input  logic       rst_n,
  plob_in_if.sink    in_ch,
  plob_out_if.source out_ch
);

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  state_t           state_r;
  plob_pkg::cmd_t   cmd_r;
  plob_pkg::probe_t probe;
  plob_pkg::level_t bid_nxt;
  plob_pkg::level_t ask_nxt;
  logic             bid_drop;
  logic             ask_drop;
  logic             in_xfer;
  logic             step;
  logic             out_valid_r;
  logic [plob_pkg::PRICE_W-1:0] bid_price_r;
  logic [plob_pkg::QTY_W-1:0]   bid_qty_r;
  logic [plob_pkg::PRICE_W-1:0] ask_price_r;
  logic [plob_pkg::QTY_W-1:0]   ask_qty_r;
  logic             bid_present_r;
  logic             ask_present_r;
  logic             dropped_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign step        = (state_r == S_APPLY) && (!out_valid_r || out_ch.ready);

  assign probe.capture = in_xfer;
  assign probe.clr     = (in_ch.req_type == plob_pkg::REQ_SNAPSHOT) ||
                         (in_ch.req_type == plob_pkg::REQ_CLEAR);
  assign probe.price   = in_ch.level_price;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r.apply  <= (in_ch.req_type == plob_pkg::REQ_UPDATE) ||
                      (in_ch.req_type == plob_pkg::REQ_SNAPSHOT);
      cmd_r.clr    <= probe.clr;
      cmd_r.side   <= in_ch.side;
      cmd_r.q_zero <= (in_ch.level_qty == '0);
      cmd_r.price  <= in_ch.level_price;
      cmd_r.qty    <= in_ch.level_qty;
    end
  end

  plob_side u_bid (
    .clk      (clk),
    .rst_n    (rst_n),
    .side_id  (plob_pkg::SIDE_BID),
    .probe    (probe),
    .step     (step),
    .cmd      (cmd_r),
    .best_nxt (bid_nxt),
    .dropped  (bid_drop)
  );

  plob_side u_ask (
    .clk      (clk),
    .rst_n    (rst_n),
    .side_id  (plob_pkg::SIDE_ASK),
    .probe    (probe),
    .step     (step),
    .cmd      (cmd_r),
    .best_nxt (ask_nxt),
    .dropped  (ask_drop)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (step) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (step) begin
      bid_price_r   <= bid_nxt.valid ? bid_nxt.price : '0;
      bid_qty_r     <= bid_nxt.valid ? bid_nxt.qty : '0;
      ask_price_r   <= ask_nxt.valid ? ask_nxt.price : '0;
      ask_qty_r     <= ask_nxt.valid ? ask_nxt.qty : '0;
      bid_present_r <= bid_nxt.valid;
      ask_present_r <= ask_nxt.valid;
      dropped_r     <= bid_drop || ask_drop;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.best_bid_price = bid_price_r;
  assign out_ch.best_bid_qty   = bid_qty_r;
  assign out_ch.best_ask_price = ask_price_r;
  assign out_ch.best_ask_qty   = ask_qty_r;
  assign out_ch.bid_present    = bid_present_r;
  assign out_ch.ask_present    = ask_present_r;
  assign out_ch.level_dropped  = dropped_r;

endmodule

/* src/plob_cell.sv */
`timescale 1ns / 1ps
// One price level of a sorted side: compare flags, then hold, update, insert or shift.
// Depends on plob_pkg.
module plob_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             is_bid,
  input  logic             target,
  input  logic             any_match,
  input  plob_pkg::probe_t probe,
  input  logic             step,
  input  plob_pkg::cmd_t   cmd,
  input  plob_pkg::level_t prev,
  input  logic             prev_ins,
  input  plob_pkg::level_t next,
  output plob_pkg::level_t lvl,
  output plob_pkg::level_t lvl_nxt,
  output logic             match_r,
  output logic             ins_r
);

  plob_pkg::level_t lvl_r;
  logic             veff;
  logic             pveff;
  logic             nveff;
  logic             cap_v;
  logic             cap_above;

  assign lvl = lvl_r;

  assign cap_v     = lvl_r.valid & ~probe.clr;
  assign cap_above = is_bid ? (probe.price > lvl_r.price) : (probe.price < lvl_r.price);

  assign veff  = lvl_r.valid & ~cmd.clr;
  assign pveff = prev.valid & ~cmd.clr;
  assign nveff = next.valid & ~cmd.clr;

  always_comb begin
    lvl_nxt       = lvl_r;
    lvl_nxt.valid = veff;
    if (cmd.apply && target) begin
      if (any_match) begin
        if (!cmd.q_zero) begin
          if (match_r) begin
            lvl_nxt.qty = cmd.qty;
          end
        end else if (match_r || ins_r) begin
          lvl_nxt       = next;
          lvl_nxt.valid = nveff;
        end
      end else if (!cmd.q_zero && ins_r) begin
        if (prev_ins) begin
          lvl_nxt       = prev;
          lvl_nxt.valid = pveff;
        end else begin
          lvl_nxt.valid = 1'b1;
          lvl_nxt.price = cmd.price;
          lvl_nxt.qty   = cmd.qty;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r.valid <= 1'b0;
    end else if (step) begin
      lvl_r.valid <= lvl_nxt.valid;
    end
    if (step) begin
      lvl_r.price <= lvl_nxt.price;
      lvl_r.qty   <= lvl_nxt.qty;
    end
  end

  always_ff @(posedge clk) begin
    if (probe.capture) begin
      match_r <= cap_v && (lvl_r.price == probe.price);
      ins_r   <= !cap_v || cap_above;
    end
  end

endmodule

/* src/plob_side.sv */
`timescale 1ns / 1ps
// One side of the book: a chain of LEVELS cells, best level in cell 0.
// Depends on plob_pkg and plob_cell.
module plob_side (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             side_id,
  input  plob_pkg::probe_t probe,
  input  logic             step,
  input  plob_pkg::cmd_t   cmd,
  output plob_pkg::level_t best_nxt,
  output logic             dropped
);

  plob_pkg::level_t                lvl [plob_pkg::LEVELS];
  plob_pkg::level_t                cell_nxt [plob_pkg::LEVELS];
  logic [plob_pkg::LEVELS-1:0]     match;
  logic [plob_pkg::LEVELS-1:0]     ins;
  logic                            any_match;
  logic                            target;
  logic                            is_bid;

  assign is_bid    = (side_id == plob_pkg::SIDE_BID);
  assign target    = (cmd.side == side_id);
  assign any_match = |match;
  assign best_nxt  = cell_nxt[0];

  assign dropped = cmd.apply && target && !any_match && !cmd.q_zero &&
                   lvl[plob_pkg::LEVELS-1].valid && !cmd.clr;

  for (genvar k = 0; k < plob_pkg::LEVELS; k++) begin : g_cell
    plob_pkg::level_t prev_lvl;
    plob_pkg::level_t next_lvl;
    logic             prev_ins;

    if (k == 0) begin : g_first
      assign prev_lvl = '0;
      assign prev_ins = 1'b0;
    end else begin : g_mid
      assign prev_lvl = lvl[k-1];
      assign prev_ins = ins[k-1];
    end

    if (k == plob_pkg::LEVELS - 1) begin : g_last
      assign next_lvl = '0;
    end else begin : g_body
      assign next_lvl = lvl[k+1];
    end

    plob_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .is_bid    (is_bid),
      .target    (target),
      .any_match (any_match),
      .probe     (probe),
      .step      (step),
      .cmd       (cmd),
      .prev      (prev_lvl),
      .prev_ins  (prev_ins),
      .next      (next_lvl),
      .lvl       (lvl[k]),
      .lvl_nxt   (cell_nxt[k]),
      .match_r   (match[k]),
      .ins_r     (ins[k])
    );
  end

endmodule
